// ----- hdl/bsc_pkg.sv -----
// ----------------------------------------------------------------------------
// Barometric sensor compensation package
// Types and constants shared by the compensation front end, queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;
    localparam int QUO_W       = 63;
    localparam int DIV_W       = 48;

    localparam logic signed [64:0] NUM_LIMIT = 65'sd2951479051793528;
    localparam logic signed [63:0] Q_LIMIT   = 64'sd137438953472;

    typedef enum logic [2:0] {
        REG_T1,
        REG_T2,
        REG_T3,
        REG_P1,
        REG_P23,
        REG_P45,
        REG_P67,
        REG_P89
    } t_reg;

    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
    } t_in;

    typedef struct packed {
        logic signed [14:0] temp_tenths;
        logic [19:0]        press_pa;
        logic               press_valid;
    } t_out;

    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_cal;

    typedef struct packed {
        logic signed [14:0]       tenths;
        logic signed [63:0]       prod;
        logic signed [DIV_W-1:0]  div;
    } t_mid;

    typedef struct packed {
        logic signed [14:0] tenths;
        logic               qneg;
        logic               pvalid;
    } t_side;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [QUO_W-1:0] num;
        logic [QUO_W-1:0] quo;
        logic [DIV_W-1:0] dmag;
        t_side            side;
    } t_dstg;

endpackage

`default_nettype wire

// ----- hdl/bsc_fifo.sv -----
// ----------------------------------------------------------------------------
// Compensation queue
// Short register queue between the front end and the divider back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_fifo #(
    parameter int DEPTH = bsc_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bsc_pkg::t_mid i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output bsc_pkg::t_mid o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bsc_pkg::t_mid r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bsc_front.sv -----
// ----------------------------------------------------------------------------
// Compensation front end
// Computes temperature, fine temperature, pressure divisor and scaled numerator.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bsc_pkg::t_cal i_cal,
    input  logic          i_valid,
    output logic          o_ready,
    input  bsc_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output bsc_pkg::t_mid o_data
);

    localparam int NS = 11;

    logic [NS-1:0] r_vld;
    logic          w_en;

    logic signed [17:0] n_a1;
    logic signed [16:0] n_d1;
    logic signed [17:0] r_a1;
    logic signed [16:0] r_d1;
    logic signed [33:0] r_m2;
    logic signed [33:0] r_dd2;
    logic signed [33:0] w_sh3;
    logic signed [33:0] w_dd3;
    logic signed [21:0] w_ddt;
    logic signed [22:0] r_v13;
    logic signed [37:0] r_m3;
    logic signed [37:0] w_t4;
    logic signed [24:0] r_tf;
    logic signed [24:0] w_tb;
    logic signed [24:0] w_tq;
    logic signed [25:0] r_x;
    logic signed [14:0] r_ten5, r_ten6, r_ten7, r_ten8, r_ten9, r_ten10, r_ten11;
    logic signed [51:0] r_xx;
    logic signed [41:0] r_xp5, r_xp2, r_xp5b, r_xp2b;
    logic signed [67:0] w_a6;
    logic signed [67:0] w_a3;
    logic signed [63:0] r_a6, r_a3;
    logic signed [63:0] r_v2, r_v1b;
    logic signed [63:0] w_hi;
    logic signed [46:0] w_hi47;
    logic signed [63:0] r_hp;
    logic [32:0]        r_lp;
    logic signed [64:0] r_nraw;
    logic signed [52:0] w_base;
    logic signed [63:0] w_ds;
    logic signed [63:0] w_dsh;
    logic signed [bsc_pkg::DIV_W-1:0] r_div10, r_div11;
    logic signed [63:0] r_num;
    logic signed [63:0] r_prod;
    logic [19:0] r_ap1, r_ap2, r_ap3, r_ap4, r_ap5, r_ap6, r_ap7, r_ap8;

    assign w_en    = !r_vld[NS-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[NS-1];
    assign o_data  = '{tenths: r_ten11, prod: r_prod, div: r_div11};

    assign n_a1 = $signed({1'b0, i_data.raw_temp[19:3]}) - $signed({1'b0, i_cal.t1, 1'b0});
    assign n_d1 = $signed({1'b0, i_data.raw_temp[19:4]}) - $signed({1'b0, i_cal.t1});

    assign w_sh3 = r_m2 >>> 11;
    assign w_dd3 = r_dd2 >>> 12;
    assign w_ddt = w_dd3[21:0];
    assign w_t4  = r_m3 >>> 14;
    assign w_tb  = r_tf + (r_tf[24] ? 25'sd511 : 25'sd0);
    assign w_tq  = w_tb >>> 9;
    assign w_a6  = r_xx * i_cal.p6;
    assign w_a3  = r_xx * i_cal.p3;
    assign w_hi  = r_v1b >>> 17;
    assign w_hi47 = w_hi[46:0];
    assign w_base = $signed({1'b0, 21'h100000 - {1'b0, r_ap8}, 31'b0});
    assign w_ds  = r_hp + 64'(r_lp >> 17);
    assign w_dsh = w_ds >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a1  <= n_a1;
            r_d1  <= n_d1;
            r_ap1 <= i_data.raw_press;

            r_m2  <= r_a1 * i_cal.t2;
            r_dd2 <= r_d1 * r_d1;
            r_ap2 <= r_ap1;

            r_v13 <= w_sh3[22:0];
            r_m3  <= w_ddt * i_cal.t3;
            r_ap3 <= r_ap2;

            r_tf  <= 25'(r_v13) + w_t4[24:0];
            r_ap4 <= r_ap3;

            r_x   <= 26'(r_tf) - 26'sd128000;
            if (w_tq < -25'sd4000) begin
                r_ten5 <= -15'sd4000;
            end else if (w_tq > 25'sd8500) begin
                r_ten5 <= 15'sd8500;
            end else begin
                r_ten5 <= w_tq[14:0];
            end
            r_ap5 <= r_ap4;

            r_xx   <= r_x * r_x;
            r_xp5  <= r_x * i_cal.p5;
            r_xp2  <= r_x * i_cal.p2;
            r_ten6 <= r_ten5;
            r_ap6  <= r_ap5;

            r_a6   <= w_a6[63:0];
            r_a3   <= w_a3[63:0];
            r_xp5b <= r_xp5;
            r_xp2b <= r_xp2;
            r_ten7 <= r_ten6;
            r_ap7  <= r_ap6;

            r_v2   <= r_a6 + (64'(r_xp5b) <<< 17) + (64'(i_cal.p4) <<< 35);
            r_v1b  <= (r_a3 >>> 8) + (64'(r_xp2b) <<< 12) + 64'sd140737488355328;
            r_ten8 <= r_ten7;
            r_ap8  <= r_ap7;

            r_hp   <= w_hi47 * $signed({1'b0, i_cal.p1});
            r_lp   <= r_v1b[16:0] * i_cal.p1;
            r_nraw <= 65'(w_base) - 65'(r_v2);
            r_ten9 <= r_ten8;

            r_div10 <= w_dsh[bsc_pkg::DIV_W-1:0];
            if (r_nraw > bsc_pkg::NUM_LIMIT) begin
                r_num <= bsc_pkg::NUM_LIMIT[63:0];
            end else if (r_nraw < -bsc_pkg::NUM_LIMIT) begin
                r_num <= -(bsc_pkg::NUM_LIMIT[63:0]);
            end else begin
                r_num <= r_nraw[63:0];
            end
            r_ten10 <= r_ten9;

            r_prod  <= r_num * 64'sd3125;
            r_div11 <= r_div10;
            r_ten11 <= r_ten10;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bsc_div.sv -----
// ----------------------------------------------------------------------------
// Compensation divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [bsc_pkg::QUO_W-1:0]    i_num,
    input  logic [bsc_pkg::DIV_W-1:0]    i_dmag,
    input  bsc_pkg::t_side               i_side,
    output logic                         o_valid,
    output logic [bsc_pkg::QUO_W-1:0]    o_quo,
    output bsc_pkg::t_side               o_side
);

    localparam int NQ = bsc_pkg::QUO_W;
    localparam int NDW = bsc_pkg::DIV_W;

    bsc_pkg::t_dstg w_in [NQ];
    bsc_pkg::t_dstg r_st [NQ];
    logic [NQ-1:0]  r_sv;

    assign w_in[0] = '{rem: '0, num: i_num, quo: '0, dmag: i_dmag, side: i_side};
    assign o_valid = r_sv[NQ-1];
    assign o_quo   = r_st[NQ-1].quo;
    assign o_side  = r_st[NQ-1].side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= '0;
        end else if (i_en) begin
            r_sv <= {r_sv[NQ-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < NQ; k++) begin : g_stage
        logic [NDW:0] w_tr;
        logic [NDW:0] w_df;
        logic         w_ge;

        if (k > 0) begin : g_link
            assign w_in[k] = r_st[k-1];
        end

        assign w_tr = {w_in[k].rem, w_in[k].num[NQ-1]};
        assign w_df = w_tr - {1'b0, w_in[k].dmag};
        assign w_ge = (w_tr >= {1'b0, w_in[k].dmag});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k].rem  <= w_ge ? w_df[NDW-1:0] : w_tr[NDW-1:0];
                r_st[k].num  <= {w_in[k].num[NQ-2:0], 1'b0};
                r_st[k].quo  <= {w_in[k].quo[NQ-2:0], w_ge};
                r_st[k].dmag <= w_in[k].dmag;
                r_st[k].side <= w_in[k].side;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bsc_back.sv -----
// ----------------------------------------------------------------------------
// Compensation back end
// Divides the pressure numerator, applies the P7 to P9 corrections, saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bsc_pkg::t_cal i_cal,
    input  logic          i_valid,
    output logic          o_ready,
    input  bsc_pkg::t_mid i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output bsc_pkg::t_out o_data
);

    localparam int NQ  = bsc_pkg::QUO_W;
    localparam int NDW = bsc_pkg::DIV_W;

    logic                 w_en;
    logic                 r_vb0;
    logic [NQ-1:0]        r_nmag;
    logic [NDW-1:0]       r_dmag;
    bsc_pkg::t_side       r_side0;
    logic [63:0]          w_nabs;
    logic [NDW-1:0]       w_dabs;
    logic                 w_dv;
    logic [NQ-1:0]        w_quo;
    bsc_pkg::t_side       w_dside;
    logic signed [63:0]   w_p64;
    logic                 r_vp1, r_vp2, r_vp3, r_vp4;
    bsc_pkg::t_side       r_s1, r_s2, r_s3, r_s4;
    logic signed [37:0]   r_pc1, r_pc2, r_pc3;
    logic signed [37:0]   w_dq;
    logic signed [24:0]   w_dq25;
    logic signed [49:0]   r_dsq;
    logic signed [53:0]   r_p8p, r_p8p3;
    logic signed [65:0]   w_d9;
    logic signed [63:0]   r_d9;
    logic signed [63:0]   w_s;
    logic signed [63:0]   r_q4;
    logic signed [63:0]   w_pa;
    logic                 r_ovld;
    bsc_pkg::t_out        r_out;

    assign w_en    = !r_ovld || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_ovld;
    assign o_data  = r_out;

    assign w_nabs = i_data.prod[63] ? -i_data.prod : i_data.prod;
    assign w_dabs = i_data.div[NDW-1] ? -i_data.div : i_data.div;

    bsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_vb0),
        .i_num   (r_nmag),
        .i_dmag  (r_dmag),
        .i_side  (r_side0),
        .o_valid (w_dv),
        .o_quo   (w_quo),
        .o_side  (w_dside)
    );

    assign w_p64  = w_dside.qneg ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});
    assign w_dq   = r_pc1 >>> 13;
    assign w_dq25 = w_dq[24:0];
    assign w_d9   = r_dsq * i_cal.p9;
    assign w_s    = 64'(r_pc3) + (r_d9 >>> 25) + (64'(r_p8p3) >>> 19);
    assign w_pa   = r_q4 >>> 8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb0  <= 1'b0;
            r_vp1  <= 1'b0;
            r_vp2  <= 1'b0;
            r_vp3  <= 1'b0;
            r_vp4  <= 1'b0;
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_vb0  <= i_valid;
            r_vp1  <= w_dv;
            r_vp2  <= r_vp1;
            r_vp3  <= r_vp2;
            r_vp4  <= r_vp3;
            r_ovld <= r_vp4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nmag  <= w_nabs[NQ-1:0];
            r_dmag  <= w_dabs;
            r_side0 <= '{tenths: i_data.tenths,
                         qneg:   i_data.prod[63] ^ i_data.div[NDW-1],
                         pvalid: (i_data.div != '0)};

            if (w_p64 > bsc_pkg::Q_LIMIT - 64'sd1) begin
                r_pc1 <= 38'((bsc_pkg::Q_LIMIT - 64'sd1));
            end else if (w_p64 < -bsc_pkg::Q_LIMIT) begin
                r_pc1 <= 38'(-bsc_pkg::Q_LIMIT);
            end else begin
                r_pc1 <= w_p64[37:0];
            end
            r_s1 <= w_dside;

            r_dsq <= w_dq25 * w_dq25;
            r_p8p <= i_cal.p8 * r_pc1;
            r_pc2 <= r_pc1;
            r_s2  <= r_s1;

            r_d9   <= w_d9[63:0];
            r_p8p3 <= r_p8p;
            r_pc3  <= r_pc2;
            r_s3   <= r_s2;

            r_q4 <= (w_s >>> 8) + (64'(i_cal.p7) <<< 4);
            r_s4 <= r_s3;

            r_out.temp_tenths <= r_s4.tenths;
            r_out.press_valid <= r_s4.pvalid;
            if (!r_s4.pvalid || w_pa < 64'sd0) begin
                r_out.press_pa <= '0;
            end else if (w_pa > 64'sd1048575) begin
                r_out.press_pa <= 20'hFFFFF;
            end else begin
                r_out.press_pa <= w_pa[19:0];
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/baro_sensor_compensation.sv -----
// ----------------------------------------------------------------------------
// Barometric sensor compensation
// Calibration registers, compensation front end, queue and divider back end.
// ----------------------------------------------------------------------------
// The block takes one raw temperature and pressure pair per clock while o_ready
// is high, and returns the compensated temperature in tenths of a degree and
// pressure in pascal, one result per item, in order. Items pass through 11
// front-end stages, the queue, an input register, 63 stages of the pipelined
// divider (one quotient bit per stage), 4 correction stages and the output
// register. Write the calibration registers only while no item is in flight.
`default_nettype none

module baro_sensor_compensation #(
    parameter int QUEUE_DEPTH = bsc_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  bsc_pkg::t_in                  i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output bsc_pkg::t_out                 o_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bsc_pkg::ADDR_W-1:0]    paddr,
    input  logic [bsc_pkg::DATA_W-1:0]    pwdata,
    output logic [bsc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    logic [15:0]   r_t1, r_t2, r_t3, r_p1;
    logic [31:0]   r_p23, r_p45, r_p67, r_p89;
    bsc_pkg::t_cal w_cal;
    bsc_pkg::t_reg w_idx;
    logic          w_fv, w_fr, w_qv, w_qr;
    bsc_pkg::t_mid w_fd, w_qd;

    assign pready = 1'b1;
    assign w_idx  = bsc_pkg::t_reg'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1  <= '0;
            r_t2  <= '0;
            r_t3  <= '0;
            r_p1  <= '0;
            r_p23 <= '0;
            r_p45 <= '0;
            r_p67 <= '0;
            r_p89 <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                bsc_pkg::REG_T1:  r_t1  <= pwdata[15:0];
                bsc_pkg::REG_T2:  r_t2  <= pwdata[15:0];
                bsc_pkg::REG_T3:  r_t3  <= pwdata[15:0];
                bsc_pkg::REG_P1:  r_p1  <= pwdata[15:0];
                bsc_pkg::REG_P23: r_p23 <= pwdata;
                bsc_pkg::REG_P45: r_p45 <= pwdata;
                bsc_pkg::REG_P67: r_p67 <= pwdata;
                bsc_pkg::REG_P89: r_p89 <= pwdata;
                default:          r_t1  <= r_t1;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            bsc_pkg::REG_T1:  prdata = {16'b0, r_t1};
            bsc_pkg::REG_T2:  prdata = {16'b0, r_t2};
            bsc_pkg::REG_T3:  prdata = {16'b0, r_t3};
            bsc_pkg::REG_P1:  prdata = {16'b0, r_p1};
            bsc_pkg::REG_P23: prdata = r_p23;
            bsc_pkg::REG_P45: prdata = r_p45;
            bsc_pkg::REG_P67: prdata = r_p67;
            bsc_pkg::REG_P89: prdata = r_p89;
            default:          prdata = '0;
        endcase
    end

    assign w_cal = '{t1: r_t1, t2: r_t2, t3: r_t3, p1: r_p1,
                     p2: r_p23[15:0], p3: r_p23[31:16],
                     p4: r_p45[15:0], p5: r_p45[31:16],
                     p6: r_p67[15:0], p7: r_p67[31:16],
                     p8: r_p89[15:0], p9: r_p89[31:16]};

    bsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cal   (w_cal),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (w_fv),
        .i_ready (w_fr),
        .o_data  (w_fd)
    );

    bsc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fv),
        .o_ready (w_fr),
        .i_data  (w_fd),
        .o_valid (w_qv),
        .i_ready (w_qr),
        .o_data  (w_qd)
    );

    bsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cal   (w_cal),
        .i_valid (w_qv),
        .o_ready (w_qr),
        .i_data  (w_qd),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

`default_nettype wire
